// ----- design/clp_pkg.sv -----
// Shared types and constants for the closest-point-on-line unit.
package clp_pkg;

	localparam int unsigned COORD_W  = 32;
	localparam int unsigned LANES    = 3;
	localparam int unsigned DEN_W    = 64;   // dot(D,D) fits 64 bits
	localparam int unsigned QUOT_W   = 34;   // offset quotient never reaches 2^33
	localparam int unsigned PROD_W   = 96;   // |dot(P-O,D)| * |D_i|
	localparam int unsigned IN_W     = 9 * COORD_W;
	localparam int unsigned OUT_W    = 3 * COORD_W;

	// One division cell's view of a transaction: all three lanes share the divisor
	typedef struct packed {
		logic                                 vld;
		logic                                 zero;
		logic [DEN_W-1:0]                     den;
		logic [LANES-1:0][DEN_W-1:0]          rem;
		logic [LANES-1:0][QUOT_W-1:0]         qd;
		logic [LANES-1:0][COORD_W-1:0]        org;
		logic [LANES-1:0]                     neg;
	} clp_div_t;

endpackage

// ----- design/clp_div_cell.sv -----
// One restoring-division cell: retires one quotient bit per lane and passes on.
module clp_div_cell
	import clp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  clp_div_t din,
	output clp_div_t dout
);

	clp_div_t nxt;
	logic [DEN_W:0] trial [LANES];
	logic [LANES-1:0] ge;

	// Shift one dividend bit into the remainder, subtract when it fits
	always_comb begin
		nxt = din;
		for (int i = 0; i < LANES; i++) begin
			trial[i] = {din.rem[i], din.qd[i][QUOT_W-1]};
			ge[i] = trial[i] >= {1'b0, din.den};
			if (ge[i]) begin
				nxt.rem[i] = DEN_W'(trial[i] - {1'b0, din.den});
			end else begin
				nxt.rem[i] = trial[i][DEN_W-1:0];
			end
			nxt.qd[i] = {din.qd[i][QUOT_W-2:0], ge[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else if (en) begin
			dout <= nxt;
		end
	end

endmodule

// ----- design/clp_front.sv -----
// Front pipeline: difference, dot products, magnitude and the wide dividend.
module clp_front
	import clp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [IN_W-1:0]   in_data,
	output clp_div_t          dout
);

	logic signed [COORD_W-1:0] p [LANES];
	logic signed [COORD_W-1:0] o [LANES];
	logic signed [COORD_W-1:0] d [LANES];

	logic                      vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [COORD_W:0]   v_s1 [LANES];
	logic signed [COORD_W-1:0] d_s1 [LANES];
	logic [COORD_W-1:0]        o_s1 [LANES];

	logic signed [65:0]        vd_s2 [LANES];
	logic [DEN_W-1:0]          dd_s2 [LANES];
	logic [COORD_W-1:0]        dm_s2 [LANES], dm_s3 [LANES], dm_s4 [LANES];
	logic [COORD_W-1:0]        o_s2 [LANES], o_s3 [LANES], o_s4 [LANES], o_s5 [LANES];
	logic [LANES-1:0]          dn_s2, dn_s3, dn_s4, dn_s5;

	logic signed [66:0]        num_s3;
	logic [DEN_W-1:0]          den_s3, den_s4, den_s5;

	logic                      nneg_s4, nneg_s5;
	logic [65:0]               mag_s4;

	logic [64:0]               plo_s5 [LANES];
	logic [64:0]               phi_s5 [LANES];

	logic [COORD_W-1:0]        dmag [LANES];
	logic [PROD_W-1:0]         prod [LANES];
	clp_div_t                  nxt;

	// Unpack the input word, x/y/z of point, origin, direction
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			p[i] = in_data[i*COORD_W +: COORD_W];
			o[i] = in_data[(3+i)*COORD_W +: COORD_W];
			d[i] = in_data[(6+i)*COORD_W +: COORD_W];
			dmag[i] = d_s1[i][COORD_W-1] ? COORD_W'(-d_s1[i]) : COORD_W'(d_s1[i]);
		end
	end

	// Valid bits of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Payload stages
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < LANES; i++) begin
				// s1: P - O
				v_s1[i] <= {p[i][COORD_W-1], p[i]} - {o[i][COORD_W-1], o[i]};
				d_s1[i] <= d[i];
				o_s1[i] <= o[i];
				// s2: products
				vd_s2[i] <= v_s1[i] * d_s1[i];
				dd_s2[i] <= dmag[i] * dmag[i];
				dm_s2[i] <= dmag[i];
				dn_s2[i] <= d_s1[i][COORD_W-1];
				o_s2[i]  <= o_s1[i];
				dm_s3[i] <= dm_s2[i];
				o_s3[i]  <= o_s2[i];
				dm_s4[i] <= dm_s3[i];
				o_s4[i]  <= o_s3[i];
				// s5: split product of the 66-bit magnitude
				plo_s5[i] <= mag_s4[32:0] * dm_s4[i];
				phi_s5[i] <= mag_s4[65:33] * dm_s4[i];
				o_s5[i]  <= o_s4[i];
			end
			dn_s3 <= dn_s2;
			dn_s4 <= dn_s3;
			dn_s5 <= dn_s4;
			// s3: sums
			num_s3 <= 67'(vd_s2[0]) + 67'(vd_s2[1]) + 67'(vd_s2[2]);
			den_s3 <= dd_s2[0] + dd_s2[1] + dd_s2[2];
			// s4: magnitude of the numerator
			nneg_s4 <= num_s3[66];
			mag_s4  <= num_s3[66] ? 66'(-num_s3) : num_s3[65:0];
			den_s4  <= den_s3;
			nneg_s5 <= nneg_s4;
			den_s5  <= den_s4;
		end
	end

	// s6 input: assemble the dividend and seed the first division cell
	always_comb begin
		nxt = '0;
		nxt.vld  = vld_s5;
		nxt.zero = den_s5 == '0;
		nxt.den  = den_s5;
		for (int i = 0; i < LANES; i++) begin
			prod[i] = PROD_W'(plo_s5[i]) + (PROD_W'(phi_s5[i]) << 33);
			nxt.rem[i] = DEN_W'(prod[i][PROD_W-1:QUOT_W]);
			nxt.qd[i]  = prod[i][QUOT_W-1:0];
			nxt.org[i] = o_s5[i];
			nxt.neg[i] = nneg_s5 ^ dn_s5[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else if (en) begin
			dout <= nxt;
		end
	end

endmodule

// ----- design/closest_point_on_line_unit.sv -----
// Top level of the closest-point-on-line unit: front pipeline, division chain, output.
//
// Usage:
//  - s_t* carries one query per transaction: point, line origin and direction, each
//    signed fixed point (any fraction width, the result scales alike).
//  - m_t* returns the foot of the perpendicular on the infinite line, saturated,
//    with a zero-direction flag and a saturation flag in m_tuser.
//  - The pipeline is six front stages, a chain of 34 division cells (one
//    quotient bit each, all three coordinates side by side) and the output register.
//  - Throughput is one query per cycle unless the output stalls; the pipeline holds up to 41 queries.
//  - The whole pipeline moves as one: when a result waits in the output register
//    and m_tready is low, every stage holds and s_tready drops in the same cycle.
//  - Reset clears all valid bits; the block accepts queries in the first cycle after.
//  - A zero direction returns the origin with zero_direction set and clipped clear.
//  - The offset quotient is truncated toward zero before it is added to the origin.
module closest_point_on_line_unit
	import clp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// point_x, point_y, point_z, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
	input  logic [IN_W-1:0]   s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	// near_x, near_y, near_z
	output logic [OUT_W-1:0]  m_tdata,
	// zero_direction, clipped
	output logic [1:0]        m_tuser
);

	logic                en;
	clp_div_t            chain [QUOT_W+1];
	logic                m_tvalid_q;
	logic [OUT_W-1:0]    m_tdata_q;
	logic [1:0]          m_tuser_q;
	logic [OUT_W-1:0]    res;
	logic [LANES-1:0]    clip;
	logic signed [QUOT_W:0]   off [LANES];
	logic signed [QUOT_W+1:0] sum [LANES];

	// Global advance: move when the output register is free or being drained
	assign en       = !m_tvalid_q || m_tready;
	assign s_tready = en;

	clp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (s_tvalid),
		.in_data (s_tdata),
		.dout    (chain[0])
	);

	// Division chain
	for (genvar g = 0; g < QUOT_W; g++) begin : g_cell
		clp_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.din    (chain[g]),
			.dout   (chain[g+1])
		);
	end

	// Sign the offset, add to the origin and saturate
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			off[i] = chain[QUOT_W].neg[i] ? -$signed({1'b0, chain[QUOT_W].qd[i]})
			                              :  $signed({1'b0, chain[QUOT_W].qd[i]});
			sum[i] = (QUOT_W+2)'($signed(chain[QUOT_W].org[i])) + (QUOT_W+2)'(off[i]);
			clip[i] = 1'b0;
			if (chain[QUOT_W].zero) begin
				res[i*COORD_W +: COORD_W] = chain[QUOT_W].org[i];
			end else if (sum[i] > (QUOT_W+2)'(signed'(33'sh0_7FFF_FFFF))) begin
				res[i*COORD_W +: COORD_W] = 32'h7FFF_FFFF;
				clip[i] = 1'b1;
			end else if (sum[i] < (QUOT_W+2)'(signed'(33'sh1_8000_0000))) begin
				res[i*COORD_W +: COORD_W] = 32'h8000_0000;
				clip[i] = 1'b1;
			end else begin
				res[i*COORD_W +: COORD_W] = sum[i][COORD_W-1:0];
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			m_tvalid_q <= chain[QUOT_W].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata_q <= res;
			m_tuser_q <= {|clip, chain[QUOT_W].zero};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef SYNTHESIS
	// A zero direction never reports saturation
	a_zero_no_clip: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !m_tuser[1])
		else $error("zero direction reported with clipping");

	// Input side follows the output stall
	a_ready_link: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");

	// A stalled result holds its flags
	a_hold_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tuser))
		else $error("result flags changed while stalled");
`endif

endmodule
